// ----- rtl/ghsd_pkg.sv -----
// shared constants, codes and controller/datapath types of the half step detector
`default_nettype none

package ghsd_pkg;

   localparam int COORD_BITS_DEF = 14;

   localparam int DIST_W  = 15;
   localparam int TOTAL_W = 16;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;

   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_THRESHOLD  = 2'd1;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      logic     capture;
      logic     sq_en;
      axis_type axis;
      logic     acc_en;
      logic     root_step;
      logic     update;
   } ghsd_cmd_type;

   typedef struct packed {
      logic out_free;
   } ghsd_status_type;

endpackage

`default_nettype wire

// ----- rtl/ghsd_ctrl.sv -----
// controller: sequences capture, squaring, root iterations and the tracker update
`default_nettype none

module ghsd_ctrl #(
   parameter int COORD_BITS = ghsd_pkg::COORD_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire ghsd_pkg::ghsd_status_type status,
   output ghsd_pkg::ghsd_cmd_type      cmd
);
   import ghsd_pkg::*;

   localparam int RW    = COORD_BITS + 1;
   localparam int CNT_W = $clog2(RW);
   localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(3);
   localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(RW - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SQUARE = 4'b0010,
      ST_ROOT   = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.axis = AXIS_X;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
            cnt_in      = '0;
            if (req_valid) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.sq_en  = (cnt_ff != SQ_LAST);
            cmd.acc_en = (cnt_ff != '0);
            case (cnt_ff[1:0])
               2'd1:    cmd.axis = AXIS_Y;
               2'd2:    cmd.axis = AXIS_Z;
               default: cmd.axis = AXIS_X;
            endcase
            if (cnt_ff == SQ_LAST) begin
               cnt_in   = '0;
               state_in = ST_ROOT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (cnt_ff == ROOT_LAST) begin
               cnt_in   = '0;
               state_in = ST_UPDATE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            // hold until the result register can take a new transaction
            if (status.out_free) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/ghsd_datapath.sv -----
// datapath: squared distance, bit-serial root, hysteresis tracker and result register
`default_nettype none

module ghsd_datapath #(
   parameter int COORD_BITS = ghsd_pkg::COORD_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire ghsd_pkg::ghsd_cmd_type                 cmd,
   output ghsd_pkg::ghsd_status_type                   status,
   input  wire logic                                   csr_write_enable,
   input  wire logic [ghsd_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [ghsd_pkg::CSR_DATA_W-1:0]        csr_write_data,
   input  wire logic signed [COORD_BITS-1:0]           req_left_x,
   input  wire logic signed [COORD_BITS-1:0]           req_left_y,
   input  wire logic signed [COORD_BITS-1:0]           req_left_z,
   input  wire logic signed [COORD_BITS-1:0]           req_right_x,
   input  wire logic signed [COORD_BITS-1:0]           req_right_y,
   input  wire logic signed [COORD_BITS-1:0]           req_right_z,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [ghsd_pkg::DIST_W-1:0]                 rsp_half_len,
   output logic                                        rsp_half_foot,
   output logic                                        rsp_step_done,
   output logic [ghsd_pkg::TOTAL_W-1:0]                rsp_step_total,
   output logic                                        rsp_first_foot
);
   import ghsd_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int SW = 2 * DW;
   localparam int RW = COORD_BITS + 1;
   localparam int WW = (RW > DIST_W) ? RW : DIST_W;

   // captured frame
   logic signed [COORD_BITS-1:0] lx_ff, ly_ff, lz_ff, rx_ff, ry_ff, rz_ff;
   logic                         foot_right_ff;

   // squaring and root
   logic signed [COORD_BITS-1:0] sel_l, sel_r;
   logic signed [DW-1:0]         diff;
   logic [DW-1:0]                mag;
   logic [SW-1:0]                prod_ff;
   logic [SW-1:0]                acc_ff, acc_in;
   logic [RW+1:0]                rem_ff, rem_in, rem_sh, trial;
   logic [RW-1:0]                root_ff, root_in;
   logic [WW-1:0]                root_wide;
   logic [DIST_W-1:0]            frame_dist;

   // thresholds and tracker state
   logic [DIST_W-1:0] high_thr_ff, low_thr_ff;
   logic              in_high_ff, in_high_in;
   logic [DIST_W-1:0] peak_dist_ff, peak_dist_in;
   logic              peak_valid_ff, peak_valid_in;
   logic              peak_right_ff, peak_right_in;
   logic              half_count_ff, half_count_in;
   logic [DIST_W-1:0] left_len_ff, left_len_in;
   logic [DIST_W-1:0] right_len_ff, right_len_in;
   logic              start_foot_ff, start_foot_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]  half_len_ff, half_len_in;
   logic               half_foot_ff, half_foot_in;
   logic               step_done_ff, step_done_in;
   logic [TOTAL_W-1:0] step_total_ff, step_total_in;
   logic               first_foot_ff, first_foot_in;

   logic              track, fall, foot;
   logic [DIST_W-1:0] len, left_n, right_n;
   logic              start_n;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lx_ff         <= req_left_x;
         ly_ff         <= req_left_y;
         lz_ff         <= req_left_z;
         rx_ff         <= req_right_x;
         ry_ff         <= req_right_y;
         rz_ff         <= req_right_z;
         foot_right_ff <= !(req_right_z > req_left_z);
      end
   end

   always_comb begin
      case (cmd.axis)
         AXIS_Y: begin
            sel_l = ly_ff;
            sel_r = ry_ff;
         end
         AXIS_Z: begin
            sel_l = lz_ff;
            sel_r = rz_ff;
         end
         default: begin
            sel_l = lx_ff;
            sel_r = rx_ff;
         end
      endcase
   end

   assign diff = {sel_r[COORD_BITS-1], sel_r} - {sel_l[COORD_BITS-1], sel_l};
   assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);

   always_ff @(posedge clock) begin
      if (cmd.sq_en) begin
         prod_ff <= mag * mag;
      end
   end

   // restoring root, one result bit per step, radicand shifts out of the accumulator
   assign rem_sh = {rem_ff[RW-1:0], acc_ff[SW-1:SW-2]};
   assign trial  = {root_ff, 2'b01};

   always_comb begin
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (cmd.capture) begin
         acc_in  = '0;
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.acc_en) begin
         acc_in = acc_ff + prod_ff;
      end else if (cmd.root_step) begin
         acc_in = {acc_ff[SW-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[RW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root_wide  = WW'(root_ff);
   assign frame_dist = (root_wide > WW'(DIST_MAX)) ? DIST_MAX : root_wide[DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         high_thr_ff <= '0;
         low_thr_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HIGH_THRESHOLD: high_thr_ff <= csr_write_data;
            CSR_LOW_THRESHOLD:  low_thr_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // tracker
   always_comb begin
      track         = in_high_ff && (!peak_valid_ff || frame_dist > peak_dist_ff);
      peak_dist_in  = track ? frame_dist : peak_dist_ff;
      peak_right_in = track ? foot_right_ff : peak_right_ff;
      peak_valid_in = peak_valid_ff || track;
      in_high_in    = in_high_ff;
      half_count_in = half_count_ff;
      left_len_in   = left_len_ff;
      right_len_in  = right_len_ff;
      start_foot_in = start_foot_ff;
      fall          = in_high_ff && (frame_dist < low_thr_ff);

      len     = peak_valid_in ? peak_dist_in : '0;
      foot    = peak_valid_in && peak_right_in;
      left_n  = foot ? left_len_ff : len;
      right_n = foot ? len : right_len_ff;
      start_n = start_foot_ff;
      if (!foot && right_len_ff == '0) begin
         start_n = 1'b0;
      end else if (foot && left_len_ff == '0) begin
         start_n = 1'b1;
      end

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      half_len_in   = half_len_ff;
      half_foot_in  = half_foot_ff;
      step_done_in  = step_done_ff;
      step_total_in = step_total_ff;
      first_foot_in = first_foot_ff;

      if (!in_high_ff) begin
         if (frame_dist > high_thr_ff) begin
            in_high_in = 1'b1;
         end
      end else if (fall) begin
         rsp_valid_in  = 1'b1;
         half_len_in   = len;
         half_foot_in  = foot;
         step_done_in  = half_count_ff;
         step_total_in = half_count_ff ? TOTAL_W'(left_n) + TOTAL_W'(right_n) : '0;
         first_foot_in = half_count_ff ? start_n : 1'b0;
         if (half_count_ff) begin
            half_count_in = 1'b0;
            left_len_in   = '0;
            right_len_in  = '0;
            start_foot_in = 1'b0;
         end else begin
            half_count_in = 1'b1;
            left_len_in   = left_n;
            right_len_in  = right_n;
            start_foot_in = start_n;
         end
         peak_valid_in = 1'b0;
         peak_dist_in  = '0;
         peak_right_in = 1'b0;
         in_high_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_high_ff    <= 1'b0;
         peak_dist_ff  <= '0;
         peak_valid_ff <= 1'b0;
         peak_right_ff <= 1'b0;
         half_count_ff <= 1'b0;
         left_len_ff   <= '0;
         right_len_ff  <= '0;
         start_foot_ff <= 1'b0;
      end else if (cmd.update) begin
         in_high_ff    <= in_high_in;
         peak_dist_ff  <= peak_dist_in;
         peak_valid_ff <= peak_valid_in;
         peak_right_ff <= peak_right_in;
         half_count_ff <= half_count_in;
         left_len_ff   <= left_len_in;
         right_len_ff  <= right_len_in;
         start_foot_ff <= start_foot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.update) begin
         rsp_valid_ff <= rsp_valid_in;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         half_len_ff   <= half_len_in;
         half_foot_ff  <= half_foot_in;
         step_done_ff  <= step_done_in;
         step_total_ff <= step_total_in;
         first_foot_ff <= first_foot_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_half_len   = half_len_ff;
   assign rsp_half_foot  = half_foot_ff;
   assign rsp_step_done  = step_done_ff;
   assign rsp_step_total = step_total_ff;
   assign rsp_first_foot = first_foot_ff;

endmodule

`default_nettype wire

// ----- rtl/gait_half_step_detector.sv -----
// top level of the gait half step detector: controller plus datapath
`default_nettype none

// Usage
//  - req channel: one transaction per skeleton frame, six ankle coordinates in mm,
//    taken when req_valid is high and req_stall is low
//  - rsp channel: at most one transaction per frame, only on a frame where the
//    distance flag falls; it carries the half step and, every second one, the step
//  - csr port: write high_threshold (index 0) and low_threshold (index 1) while idle
//  - a result is registered once its frame has passed squaring, the root iterations
//    and the tracker update; a new frame is taken only after the previous one is
//    through all of these: squaring and summing the three axes on the single
//    multiplier, then one result bit per step of the restoring square root
//  - a new frame is taken while the previous result still waits in the output
//    register; only the tracker update holds until that register frees
//  - a stalled rsp transaction holds its payload until taken
//  - reset clears the thresholds, the tracker, the step record and rsp_valid
module gait_half_step_detector #(
   parameter int COORD_BITS = ghsd_pkg::COORD_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // configuration
   input  wire logic                             csr_write_enable,
   input  wire logic [ghsd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ghsd_pkg::CSR_DATA_W-1:0]  csr_write_data,
   // frame input
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic signed [COORD_BITS-1:0]     req_left_x,
   input  wire logic signed [COORD_BITS-1:0]     req_left_y,
   input  wire logic signed [COORD_BITS-1:0]     req_left_z,
   input  wire logic signed [COORD_BITS-1:0]     req_right_x,
   input  wire logic signed [COORD_BITS-1:0]     req_right_y,
   input  wire logic signed [COORD_BITS-1:0]     req_right_z,
   // step output
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [ghsd_pkg::DIST_W-1:0]           rsp_half_len,
   output logic                                  rsp_half_foot,
   output logic                                  rsp_step_done,
   output logic [ghsd_pkg::TOTAL_W-1:0]          rsp_step_total,
   output logic                                  rsp_first_foot
);
   import ghsd_pkg::*;

   // command and status between the sequencer and the datapath
   ghsd_cmd_type    cmd;
   ghsd_status_type status;

   // sequencer: idle, squaring, root iterations, tracker update
   ghsd_ctrl #(
      .COORD_BITS (COORD_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: frame capture, distance, hysteresis tracker and result register
   ghsd_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_left_x       (req_left_x),
      .req_left_y       (req_left_y),
      .req_left_z       (req_left_z),
      .req_right_x      (req_right_x),
      .req_right_y      (req_right_y),
      .req_right_z      (req_right_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_half_len     (rsp_half_len),
      .rsp_half_foot    (rsp_half_foot),
      .rsp_step_done    (rsp_step_done),
      .rsp_step_total   (rsp_step_total),
      .rsp_first_foot   (rsp_first_foot)
   );

endmodule

`default_nettype wire

// ----- rtl/ghsd_checker.sv -----
// port-level checks of the half step detector and their bind to the top level
`default_nettype none

module ghsd_checker #(
   parameter int COORD_BITS = ghsd_pkg::COORD_BITS_DEF
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             csr_write_enable,
   input wire logic [ghsd_pkg::CSR_INDEX_W-1:0] csr_index,
   input wire logic [ghsd_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input wire logic                             req_valid,
   input wire logic                             req_stall,
   input wire logic signed [COORD_BITS-1:0]     req_left_x,
   input wire logic signed [COORD_BITS-1:0]     req_left_y,
   input wire logic signed [COORD_BITS-1:0]     req_left_z,
   input wire logic signed [COORD_BITS-1:0]     req_right_x,
   input wire logic signed [COORD_BITS-1:0]     req_right_y,
   input wire logic signed [COORD_BITS-1:0]     req_right_z,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [ghsd_pkg::DIST_W-1:0]      rsp_half_len,
   input wire logic                             rsp_half_foot,
   input wire logic                             rsp_step_done,
   input wire logic [ghsd_pkg::TOTAL_W-1:0]     rsp_step_total,
   input wire logic                             rsp_first_foot
);
   import ghsd_pkg::*;

   // nothing comes out straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid raised right after reset");

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_half_len)
                                 && $stable(rsp_step_total))
      else $error("stalled rsp transaction changed");

   // a taken frame keeps the input busy for the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("frame taken while previous frame still in work");

   // step fields are zero on a lone half step
   a_half_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_step_done |-> rsp_step_total == '0 && !rsp_first_foot)
      else $error("step fields set on a half step");

   // the step total includes the half step that closes it
   a_total_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_done |-> rsp_step_total >= TOTAL_W'(rsp_half_len))
      else $error("step total below closing half length");

endmodule

bind gait_half_step_detector ghsd_checker #(.COORD_BITS(COORD_BITS)) u_ghsd_checker (.*);

`default_nettype wire

// ----- test/ghsd_step_checker.sv -----
// checker for the half step detector: watches both channels, predicts and compares results
`default_nettype none

module ghsd_step_checker #(
   parameter int COORD_BITS = ghsd_pkg::COORD_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [ghsd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ghsd_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  wire logic                             req_valid,
   input  wire logic                             req_stall,
   input  wire logic signed [COORD_BITS-1:0]     req_left_x,
   input  wire logic signed [COORD_BITS-1:0]     req_left_y,
   input  wire logic signed [COORD_BITS-1:0]     req_left_z,
   input  wire logic signed [COORD_BITS-1:0]     req_right_x,
   input  wire logic signed [COORD_BITS-1:0]     req_right_y,
   input  wire logic signed [COORD_BITS-1:0]     req_right_z,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   input  wire logic [ghsd_pkg::DIST_W-1:0]      rsp_half_len,
   input  wire logic                             rsp_half_foot,
   input  wire logic                             rsp_step_done,
   input  wire logic [ghsd_pkg::TOTAL_W-1:0]     rsp_step_total,
   input  wire logic                             rsp_first_foot,
   output int                                    failures,
   output int                                    pending
);

   typedef struct packed {
      logic [ghsd_pkg::DIST_W-1:0]  half_len;
      logic                         half_foot;
      logic                         step_done;
      logic [ghsd_pkg::TOTAL_W-1:0] step_total;
      logic                         first_foot;
   } half_step_type;

   // predicted thresholds, tracker and step record
   logic [ghsd_pkg::DIST_W-1:0] high_thr, low_thr;
   logic                        tracking;
   logic [ghsd_pkg::DIST_W-1:0] peak_len;
   logic                        peak_seen, peak_right;
   logic                        second_half;
   logic [ghsd_pkg::DIST_W-1:0] left_len, right_len;
   logic                        start_right;

   half_step_type expected_steps[$];
   int            mismatch_count = 0;

   function automatic logic [31:0] square_root(input logic [63:0] n);
      logic [31:0] root;
      logic [31:0] trial;
      logic [63:0] trial_sq;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial    = root | (32'd1 << b);
         trial_sq = {32'd0, trial} * {32'd0, trial};
         if (trial_sq <= n) root = trial;
      end
      return root;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   task automatic predict_frame();
      longint                      dx, dy, dz;
      logic [31:0]                 root;
      logic [ghsd_pkg::DIST_W-1:0] frame_dist;
      logic                        foot_right;
      half_step_type               step;
      dx   = longint'(req_right_x) - longint'(req_left_x);
      dy   = longint'(req_right_y) - longint'(req_left_y);
      dz   = longint'(req_right_z) - longint'(req_left_z);
      root = square_root(dx * dx + dy * dy + dz * dz);
      frame_dist = (root > {17'd0, ghsd_pkg::DIST_MAX}) ? ghsd_pkg::DIST_MAX : root[14:0];
      foot_right = !(req_right_z > req_left_z);

      // earliest frame holding the maximum keeps the peak
      if (tracking && (!peak_seen || frame_dist > peak_len)) begin
         peak_len   = frame_dist;
         peak_right = foot_right;
         peak_seen  = 1'b1;
      end

      if (!tracking) begin
         if (frame_dist > high_thr) tracking = 1'b1;
      end else if (frame_dist < low_thr) begin
         step.half_len  = peak_seen ? peak_len : '0;
         step.half_foot = peak_seen && peak_right;
         if (!step.half_foot) begin
            left_len = step.half_len;
            if (right_len == '0) start_right = 1'b0;
         end else begin
            right_len = step.half_len;
            if (left_len == '0) start_right = 1'b1;
         end
         step.step_done  = second_half;
         step.step_total = '0;
         step.first_foot = 1'b0;
         if (second_half) begin
            step.step_total = {1'b0, left_len} + {1'b0, right_len};
            step.first_foot = start_right;
            second_half     = 1'b0;
            left_len        = '0;
            right_len       = '0;
            start_right     = 1'b0;
         end else begin
            second_half = 1'b1;
         end
         peak_seen  = 1'b0;
         peak_len   = '0;
         peak_right = 1'b0;
         tracking   = 1'b0;
         expected_steps = {expected_steps, step};
      end
   endtask

   task automatic check_result();
      half_step_type want;
      if (expected_steps.size() == 0) begin
         report_mismatch("result with nothing expected, half_len", rsp_half_len, 0);
         return;
      end
      want = expected_steps.pop_front();
      if (rsp_half_len !== want.half_len)
         report_mismatch("half_len", rsp_half_len, want.half_len);
      if (rsp_half_foot !== want.half_foot)
         report_mismatch("half_foot", rsp_half_foot, want.half_foot);
      if (rsp_step_done !== want.step_done)
         report_mismatch("step_done", rsp_step_done, want.step_done);
      if (rsp_step_total !== want.step_total)
         report_mismatch("step_total", rsp_step_total, want.step_total);
      if (rsp_first_foot !== want.first_foot)
         report_mismatch("first_foot", rsp_first_foot, want.first_foot);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         high_thr    = '0;
         low_thr     = '0;
         tracking    = 1'b0;
         peak_len    = '0;
         peak_seen   = 1'b0;
         peak_right  = 1'b0;
         second_half = 1'b0;
         left_len    = '0;
         right_len   = '0;
         start_right = 1'b0;
         expected_steps.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               ghsd_pkg::CSR_HIGH_THRESHOLD: high_thr = csr_write_data;
               ghsd_pkg::CSR_LOW_THRESHOLD:  low_thr  = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) predict_frame();
      end
      failures <= mismatch_count;
      pending  <= expected_steps.size();
   end

endmodule

`default_nettype wire

// ----- test/tb_gait_half_step_detector.sv -----
// testbench top of the half step detector: stimulus, receiver stalls, watchdog and verdict
`default_nettype none

module tb_gait_half_step_detector;

   localparam int COORD_BITS      = ghsd_pkg::COORD_BITS_DEF;
   localparam int COORD_MIN       = -(1 << (COORD_BITS - 1));
   localparam int COORD_MAX       = (1 << (COORD_BITS - 1)) - 1;
   localparam int OFFSET_MAX      = COORD_MAX - COORD_MIN;
   localparam int MAX_GAP         = 14;
   localparam int SETTLE_CYCLES   = 40;     // lets the last frame drain, with margin
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 75;
   localparam logic [ghsd_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             csr_write_enable = 1'b0;
   logic [ghsd_pkg::CSR_INDEX_W-1:0] csr_index        = '0;
   logic [ghsd_pkg::CSR_DATA_W-1:0]  csr_write_data   = '0;

   logic                         req_valid   = 1'b0;
   logic                         req_stall;
   logic signed [COORD_BITS-1:0] req_left_x  = '0;
   logic signed [COORD_BITS-1:0] req_left_y  = '0;
   logic signed [COORD_BITS-1:0] req_left_z  = '0;
   logic signed [COORD_BITS-1:0] req_right_x = '0;
   logic signed [COORD_BITS-1:0] req_right_y = '0;
   logic signed [COORD_BITS-1:0] req_right_z = '0;

   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [ghsd_pkg::DIST_W-1:0]  rsp_half_len;
   logic                         rsp_half_foot;
   logic                         rsp_step_done;
   logic [ghsd_pkg::TOTAL_W-1:0] rsp_step_total;
   logic                         rsp_first_foot;

   int failures;
   int pending;

   // thresholds as last written, used to aim frame distances
   int hi_thr = 0;
   int lo_thr = 0;

   // quiet flags switch off idling on one side for a whole phase
   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;

   int frames_sent = 0;
   int stall_left  = 0;
   int stall_draw;
   int quiet_cycles = 0;
   int phase_end;
   int mean_mm;
   int hi_pick, lo_pick;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   gait_half_step_detector #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_left_x      (req_left_x),
      .req_left_y      (req_left_y),
      .req_left_z      (req_left_z),
      .req_right_x     (req_right_x),
      .req_right_y     (req_right_y),
      .req_right_z     (req_right_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_half_len    (rsp_half_len),
      .rsp_half_foot   (rsp_half_foot),
      .rsp_step_done   (rsp_step_done),
      .rsp_step_total  (rsp_step_total),
      .rsp_first_foot  (rsp_first_foot)
   );

   ghsd_step_checker #(
      .COORD_BITS(COORD_BITS)
   ) step_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_left_x      (req_left_x),
      .req_left_y      (req_left_y),
      .req_left_z      (req_left_z),
      .req_right_x     (req_right_x),
      .req_right_y     (req_right_y),
      .req_right_z     (req_right_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_half_len    (rsp_half_len),
      .rsp_half_foot   (rsp_half_foot),
      .rsp_step_done   (rsp_step_done),
      .rsp_step_total  (rsp_step_total),
      .rsp_first_foot  (rsp_first_foot),
      .failures        (failures),
      .pending         (pending)
   );

   // receiver: each transaction waits a drawn number of cycles after it shows up,
   // the draw is made when the previous one is taken
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_draw = rsp_quiet ? 0 : $urandom_range(0, MAX_GAP);
         stall_left <= stall_draw;
         rsp_stall  <= (stall_draw != 0);
      end else if (rsp_valid && stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left != 1);
      end
   end

   // watchdog: too long without any transaction or register write ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
      begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("gait_half_step_detector test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one frame transaction after a drawn gap; returns at the accepting edge, valid still high
   task automatic send_frame(input int lx, ly, lz, rx, ry, rz);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_left_x  <= lx[COORD_BITS-1:0];
      req_left_y  <= ly[COORD_BITS-1:0];
      req_left_z  <= lz[COORD_BITS-1:0];
      req_right_x <= rx[COORD_BITS-1:0];
      req_right_y <= ry[COORD_BITS-1:0];
      req_right_z <= rz[COORD_BITS-1:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      frames_sent++;
   endtask

   // right ankle = left ankle + offset, left placed at random where both stay in range
   task automatic send_offset(input int ox, oy, oz);
      int offs[3];
      int left[3];
      int lo_pos, hi_pos;
      offs = '{ox, oy, oz};
      for (int i = 0; i < 3; i++) begin
         lo_pos  = (COORD_MIN - offs[i] > COORD_MIN) ? COORD_MIN - offs[i] : COORD_MIN;
         hi_pos  = (COORD_MAX - offs[i] < COORD_MAX) ? COORD_MAX - offs[i] : COORD_MAX;
         left[i] = lo_pos + int'($urandom_range(0, hi_pos - lo_pos));
      end
      send_frame(left[0], left[1], left[2],
                 left[0] + offs[0], left[1] + offs[1], left[2] + offs[2]);
   endtask

   // a frame whose ankle distance is at least a drawn value in [lo_d, hi_d],
   // and at most about 1.6 percent above it
   task automatic send_dist(input int lo_d, hi_d);
      int offs[3];
      int d, side, axis;
      if (lo_d > OFFSET_MAX) lo_d = OFFSET_MAX;
      if (hi_d > OFFSET_MAX) hi_d = OFFSET_MAX;
      if (hi_d < lo_d) hi_d = lo_d;
      d    = lo_d + int'($urandom_range(0, hi_d - lo_d));
      side = d / 8;
      axis = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++)
         offs[i] = int'($urandom_range(0, 2 * side)) - side;
      offs[axis] = $urandom_range(0, 1) ? -d : d;
      send_offset(offs[0], offs[1], offs[2]);
   endtask

   task automatic send_above();
      send_dist(hi_thr + 1, hi_thr + 1 + hi_thr / 4 + 50);
   endtask

   task automatic send_below();
      if (lo_thr == 0) send_dist(0, 0);
      else send_dist(0, (lo_thr * 7) / 8);
   endtask

   task automatic send_between();
      if (lo_thr <= hi_thr) send_dist(lo_thr, hi_thr);
      else send_dist(hi_thr, lo_thr);
   endtask

   task automatic send_noise();
      send_frame(COORD_MIN + int'($urandom_range(0, OFFSET_MAX)),
                 COORD_MIN + int'($urandom_range(0, OFFSET_MAX)),
                 COORD_MIN + int'($urandom_range(0, OFFSET_MAX)),
                 COORD_MIN + int'($urandom_range(0, OFFSET_MAX)),
                 COORD_MIN + int'($urandom_range(0, OFFSET_MAX)),
                 COORD_MIN + int'($urandom_range(0, OFFSET_MAX)));
   endtask

   // well-formed half step: settle low, rise, a few tracked frames, fall
   task automatic send_half_step();
      repeat ($urandom_range(0, 2)) send_below();
      send_above();
      repeat ($urandom_range(0, 5)) begin
         if ($urandom_range(0, 1)) send_above();
         else send_between();
      end
      send_below();
   endtask

   // drop valid, wait for every expected result, then let the last frame drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_thresholds(input int hi, lo);
      settle();
      csr_write_enable <= 1'b1;
      csr_index        <= ghsd_pkg::CSR_HIGH_THRESHOLD;
      csr_write_data   <= hi[ghsd_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index        <= ghsd_pkg::CSR_LOW_THRESHOLD;
      csr_write_data   <= lo[ghsd_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      hi_thr = hi;
      lo_thr = lo;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // a write to an index with no register behind it must change nothing
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_UNUSED_INDEX;
      csr_write_data   <= '1;
      @(posedge clock);
      csr_write_enable <= 1'b0;

      // directed part at high 1000, low 900
      write_thresholds(1000, 900);
      // extreme coordinates: largest distance, peak tie keeps the earlier right foot
      send_frame(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
      send_frame(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
      send_frame(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
      send_frame(0, 0, 0, 0, 0, 0);
      // left half step closes the pair that a right one began
      send_offset(2000, 0, 0);
      send_offset(0, 0, 1500);
      send_offset(0, -1200, 0);
      send_offset(50, 0, -50);
      // right foot twice in one pair
      send_offset(0, 3000, 0);
      send_offset(0, 0, -3000);
      send_offset(0, 0, 500);
      send_offset(-5000, 0, 0);
      send_offset(0, 0, -4000);
      send_offset(0, 0, 0);
      // threshold edges: equal to high does not rise, equal to low does not fall
      send_offset(950, 0, 0);
      send_offset(0, 1000, 0);
      send_offset(0, 0, 1001);
      send_offset(900, 0, 0);
      send_offset(0, 899, 0);
      // falling frame as the only tracked frame, equal z counts as right
      send_offset(0, 0, -2000);
      send_offset(0, 0, 0);
      // widest single-axis offset, then the far corners, then a near miss
      send_offset(OFFSET_MAX, 0, 0);
      send_offset(-OFFSET_MAX, -OFFSET_MAX, -OFFSET_MAX);
      send_offset(0, 0, 1);

      // random phases, each with its own thresholds and idling mix
      for (int phase = 0; phase < PHASES; phase++) begin
         mean_mm = $urandom_range(20, 20000);
         hi_pick = mean_mm + mean_mm / 10;
         lo_pick = mean_mm - mean_mm / 10;
         case (phase)
            0: begin hi_pick = 0;     lo_pick = 32767; end  // rise and fall on alternate frames
            1: begin hi_pick = 32767; lo_pick = 32767; end  // never rises
            2: begin hi_pick = 0;     lo_pick = 0;     end  // rises once, never falls
            4: begin
               hi_pick = $urandom_range(0, 30000);
               lo_pick = $urandom_range(0, 30000);
            end
            default: ;
         endcase
         write_thresholds(hi_pick, lo_pick);
         req_quiet = (phase == 3) || ($urandom_range(0, 3) == 0);
         rsp_quiet = (phase == 3) || ($urandom_range(0, 3) == 0);
         phase_end = frames_sent + ITEMS_PER_PHASE;
         while (frames_sent < phase_end) begin
            if ($urandom_range(0, 9) < 2) send_noise();
            else send_half_step();
         end
      end

      settle();
      if (failures == 0) begin
         $display("gait_half_step_detector test passed");
      end else begin
         $display("gait_half_step_detector test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
